// ----- sv/adts_pkg.sv -----
// Shared types, constants and the sampling-rate table of the ADTS deframer.
package adts_pkg;

   localparam int HEADER_BYTES = 7;
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 8;
   localparam int LEN_BITS = 13;
   localparam int FIELD_BITS = 6;
   localparam int FNUM_BITS = 32;
   localparam int RATE_BITS = 17;
   localparam int HDR_IDX_BITS = $clog2(HEADER_BYTES);

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [3:0] SYNC_NIBBLE = 4'hF;
   localparam logic [HDR_IDX_BITS-1:0] HDR_LAST = HDR_IDX_BITS'(HEADER_BYTES - 1);
   localparam logic [LEN_BITS-1:0] HDR_LEN = LEN_BITS'(HEADER_BYTES);

   typedef struct packed {
      logic                               is_hdr;
      logic [HEADER_BYTES-1:0][7:0]       bytes;
      logic [LEN_BITS-1:0]                pos;
      logic [LEN_BITS-1:0]                len;
      logic [FIELD_BITS-1:0]              fields;
      logic [FNUM_BITS-1:0]               fnum;
   } entry_type;

   function automatic logic [RATE_BITS-1:0] rate_hz(input logic [3:0] idx);
      logic [RATE_BITS-1:0] r;
      unique case (idx)
         4'd0:    r = RATE_BITS'(96000);
         4'd1:    r = RATE_BITS'(88200);
         4'd2:    r = RATE_BITS'(64000);
         4'd3:    r = RATE_BITS'(48000);
         4'd4:    r = RATE_BITS'(44100);
         4'd5:    r = RATE_BITS'(32000);
         4'd6:    r = RATE_BITS'(24000);
         4'd7:    r = RATE_BITS'(22050);
         4'd8:    r = RATE_BITS'(16000);
         4'd9:    r = RATE_BITS'(12000);
         4'd10:   r = RATE_BITS'(11025);
         4'd11:   r = RATE_BITS'(8000);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/adts_frame_deframer_top.sv -----
// Top level of the ADTS frame deframer: front end, transaction queue, back end.
// A payload byte reaches rsp through the queue memory and then the output register; a
// valid header is pushed as one entry with its seventh byte and put out as seven results.
// Throughput: one input byte and one result per cycle while no stall is raised, set
// by the single output register; header bursts are absorbed by the eight-entry queue.
// Synchronous reset clears phase, counters, queue pointers and output valid.
module adts_frame_deframer_top
   import adts_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_byte_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_frame_start,
   output logic                   rsp_frame_last,
   output logic [LEN_BITS-1:0]    rsp_byte_position,
   output logic [LEN_BITS-1:0]    rsp_frame_length,
   output logic [1:0]             rsp_profile_code,
   output logic [3:0]             rsp_rate_index,
   output logic [RATE_BITS-1:0]   rsp_sample_rate_hz,
   output logic [FNUM_BITS-1:0]   rsp_frame_number
);

   logic        push, pop, full, empty;
   entry_type   push_entry, head;

   adts_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_byte_in (req_byte_in),
      .full        (full),
      .req_stall   (req_stall),
      .push        (push),
      .push_entry  (push_entry)
   );

   adts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   adts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .head               (head),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_profile_code   (rsp_profile_code),
      .rsp_rate_index     (rsp_rate_index),
      .rsp_sample_rate_hz (rsp_sample_rate_hz),
      .rsp_frame_number   (rsp_frame_number)
   );

endmodule

// ----- sv/adts_front.sv -----
// Front end: sync hunt, header capture and classification of stream bytes.
module adts_front
   import adts_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [7:0]      req_byte_in,
   input  logic            full,
   output logic            req_stall,
   output logic            push,
   output entry_type       push_entry
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_SYNC    = 2'd1;
   localparam logic [1:0] PH_HEADER  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;
   localparam int FN_COPY = (COUNT_BITS < FNUM_BITS) ? COUNT_BITS : FNUM_BITS;

   logic [1:0]              phase_ff, phase_in;
   logic [LEN_BITS-1:0]     pos_ff, pos_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;
   logic [FIELD_BITS-1:0]   fields_ff, fields_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [7:0]              hdr_ff [HEADER_BYTES-1];

   logic                    accept;
   logic [LEN_BITS-1:0]     hdr_len;
   logic [COUNT_BITS-1:0]   cnt_next;
   logic [LEN_BITS:0]       pos_plus;
   logic [FNUM_BITS-1:0]    fnum_cur, fnum_next;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign hdr_len   = {hdr_ff[3][1:0], hdr_ff[4], hdr_ff[5][7:5]};
   assign cnt_next  = cnt_ff + COUNT_BITS'(1);
   assign pos_plus  = {1'b0, pos_ff} + (LEN_BITS+1)'(1);

   always_comb begin
      fnum_cur  = '0;
      fnum_next = '0;
      fnum_cur[FN_COPY-1:0]  = cnt_ff[FN_COPY-1:0];
      fnum_next[FN_COPY-1:0] = cnt_next[FN_COPY-1:0];
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      fields_in  = fields_ff;
      cnt_in     = cnt_ff;
      push       = 1'b0;
      push_entry = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_byte_in == SYNC_BYTE) begin
                  phase_in = PH_SYNC;
               end
            end
            PH_SYNC: begin
               if (req_byte_in[7:4] == SYNC_NIBBLE) begin
                  pos_in   = LEN_BITS'(2);
                  phase_in = PH_HEADER;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_HEADER: begin
               pos_in = pos_ff + LEN_BITS'(1);
               if (pos_ff[HDR_IDX_BITS-1:0] == HDR_LAST) begin
                  if (hdr_len < HDR_LEN) begin
                     phase_in = PH_HUNT;
                     pos_in   = '0;
                  end else begin
                     len_in    = hdr_len;
                     fields_in = hdr_ff[2][7:2];
                     cnt_in    = cnt_next;
                     push      = 1'b1;
                     push_entry.is_hdr = 1'b1;
                     for (int i = 0; i < HEADER_BYTES - 1; i++) begin
                        push_entry.bytes[i] = hdr_ff[i];
                     end
                     push_entry.bytes[HEADER_BYTES-1] = req_byte_in;
                     push_entry.len    = hdr_len;
                     push_entry.fields = hdr_ff[2][7:2];
                     push_entry.fnum   = fnum_next;
                     if (hdr_len == HDR_LEN) begin
                        phase_in = PH_HUNT;
                        pos_in   = '0;
                     end else begin
                        phase_in = PH_PAYLOAD;
                        pos_in   = HDR_LEN;
                     end
                  end
               end
            end
            default: begin
               push              = 1'b1;
               push_entry.bytes[0] = req_byte_in;
               push_entry.pos    = pos_ff;
               push_entry.len    = len_ff;
               push_entry.fields = fields_ff;
               push_entry.fnum   = fnum_cur;
               pos_in            = pos_plus[LEN_BITS-1:0];
               if (pos_plus >= {1'b0, len_ff}) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         pos_ff    <= '0;
         len_ff    <= '0;
         fields_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         fields_ff <= fields_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (phase_ff == PH_HUNT) begin
            hdr_ff[0] <= req_byte_in;
         end
         if (phase_ff == PH_SYNC) begin
            hdr_ff[1] <= req_byte_in;
         end
         if (phase_ff == PH_HEADER && pos_ff[HDR_IDX_BITS-1:0] != HDR_LAST) begin
            hdr_ff[pos_ff[HDR_IDX_BITS-1:0]] <= req_byte_in;
         end
      end
   end

   a_payload_in_frame: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (pos_ff < len_ff && len_ff > HDR_LEN))
      else $error("payload position outside frame");

   a_header_len: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.is_hdr |-> push_entry.len >= HDR_LEN)
      else $error("header pushed with short length");

endmodule

// ----- sv/adts_queue.sv -----
// Short queue of classified transactions between front and back end.
module adts_queue
   import adts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  entry_type   push_entry,
   input  logic        pop,
   output logic        full,
   output logic        empty,
   output entry_type   head
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ff, wr_in;
   logic [PTR_BITS-1:0]    rd_ff, rd_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_BITS'(1);
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

// ----- sv/adts_back.sv -----
// Back end: expands header bursts and drives the registered result channel.
module adts_back
   import adts_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  entry_type              head,
   output logic                   pop,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_frame_start,
   output logic                   rsp_frame_last,
   output logic [LEN_BITS-1:0]    rsp_byte_position,
   output logic [LEN_BITS-1:0]    rsp_frame_length,
   output logic [1:0]             rsp_profile_code,
   output logic [3:0]             rsp_rate_index,
   output logic [RATE_BITS-1:0]   rsp_sample_rate_hz,
   output logic [FNUM_BITS-1:0]   rsp_frame_number
);

   logic                      valid_ff, valid_in;
   logic [HDR_IDX_BITS-1:0]   idx_ff, idx_in;
   logic                      load;
   logic [LEN_BITS-1:0]       pos;
   logic [LEN_BITS:0]         pos_plus;

   logic [7:0]                data_ff;
   logic                      start_ff, last_ff;
   logic [LEN_BITS-1:0]       pos_ff, len_ff;
   logic [1:0]                prof_ff;
   logic [3:0]                ridx_ff;
   logic [RATE_BITS-1:0]      hz_ff;
   logic [FNUM_BITS-1:0]      fnum_ff;

   assign load     = !empty && (!valid_ff || !rsp_stall);
   assign pop      = load && (!head.is_hdr || idx_ff == HDR_LAST);
   assign pos      = head.is_hdr ? LEN_BITS'(idx_ff) : head.pos;
   assign pos_plus = {1'b0, pos} + (LEN_BITS+1)'(1);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = pop ? '0 : idx_ff + HDR_IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= head.is_hdr ? head.bytes[idx_ff] : head.bytes[0];
         start_ff <= (pos == '0);
         last_ff  <= (pos_plus == {1'b0, head.len});
         pos_ff   <= pos;
         len_ff   <= head.len;
         prof_ff  <= head.fields[5:4];
         ridx_ff  <= head.fields[3:0];
         hz_ff    <= rate_hz(head.fields[3:0]);
         fnum_ff  <= head.fnum;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_data_byte      = data_ff;
   assign rsp_frame_start    = start_ff;
   assign rsp_frame_last     = last_ff;
   assign rsp_byte_position  = pos_ff;
   assign rsp_frame_length   = len_ff;
   assign rsp_profile_code   = prof_ff;
   assign rsp_rate_index     = ridx_ff;
   assign rsp_sample_rate_hz = hz_ff;
   assign rsp_frame_number   = fnum_ff;

   a_burst_on_header: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> (!empty && head.is_hdr))
      else $error("burst index set without header at queue head");

endmodule

// ----- test/testbench.sv -----
// Testbench for the ADTS frame deframer: byte stream in, checked frame transactions out.
module testbench;
   import adts_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 270;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [7:0]           data;
      logic                 start;
      logic                 last;
      logic [LEN_BITS-1:0]  pos;
      logic [LEN_BITS-1:0]  len;
      logic [1:0]           prof;
      logic [3:0]           idx;
      logic [RATE_BITS-1:0] hz;
      logic [FNUM_BITS-1:0] fnum;
   } frame_byte_type;

   class frame_scoreboard;
      typedef enum logic [1:0] {HUNTING, SYNC_SEEN, IN_HEADER, IN_PAYLOAD} deframe_phase_type;

      deframe_phase_type    phase;
      logic [7:0]           hdr [HEADER_BYTES];
      logic [LEN_BITS-1:0]  pos;
      logic [LEN_BITS-1:0]  length;
      logic [FIELD_BITS-1:0] fields;
      logic [FNUM_BITS-1:0] frames_seen;
      logic [RATE_BITS-1:0] hz_of_index [16];
      frame_byte_type       expected_bytes [$];
      int                   errors;
      int                   checked;

      function new();
         phase = HUNTING;
         pos = '0;
         length = '0;
         fields = '0;
         frames_seen = '0;
         errors = 0;
         checked = 0;
         hz_of_index = '{17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
                         17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
                         17'd0, 17'd0, 17'd0, 17'd0};
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void push_expected(logic [7:0] b, logic [LEN_BITS-1:0] p);
         frame_byte_type e;
         e.data = b;
         e.start = (p == '0);
         e.last = (int'(p) + 1 == int'(length));
         e.pos = p;
         e.len = length;
         e.prof = fields[5:4];
         e.idx = fields[3:0];
         e.hz = hz_of_index[fields[3:0]];
         e.fnum = frames_seen;
         expected_bytes.push_back(e);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [LEN_BITS-1:0] hdr_len;
         case (phase)
            HUNTING: begin
               if (b == SYNC_BYTE) begin
                  hdr[0] = b;
                  phase = SYNC_SEEN;
               end
            end
            SYNC_SEEN: begin
               if (b[7:4] == SYNC_NIBBLE) begin
                  hdr[1] = b;
                  pos = LEN_BITS'(2);
                  phase = IN_HEADER;
               end else begin
                  phase = HUNTING;
               end
            end
            IN_HEADER: begin
               hdr[pos] = b;
               pos = pos + 1'b1;
               if (pos == HDR_LEN) begin
                  hdr_len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
                  if (hdr_len < HDR_LEN) begin
                     phase = HUNTING;
                     pos = '0;
                  end else begin
                     length = hdr_len;
                     fields = hdr[2][7:2];
                     frames_seen = frames_seen + 1'b1;
                     for (int i = 0; i < HEADER_BYTES; i++)
                        push_expected(hdr[i], LEN_BITS'(i));
                     if (hdr_len == HDR_LEN) begin
                        phase = HUNTING;
                        pos = '0;
                     end else begin
                        phase = IN_PAYLOAD;
                     end
                  end
               end
            end
            default: begin
               push_expected(b, pos);
               pos = pos + 1'b1;
               if (pos >= length) begin
                  phase = HUNTING;
                  pos = '0;
               end
            end
         endcase
      endfunction

      task report(string what);
         if (errors < MAX_PRINTED)
            $display("mismatch at result %0d: %s", checked, what);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(frame_byte_type got);
         frame_byte_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected transaction, data %02h position %0d", got.data,
                             got.pos));
         end else begin
            want = expected_bytes.pop_front();
            compare_field("data_byte", 32'(got.data), 32'(want.data));
            compare_field("frame_start", 32'(got.start), 32'(want.start));
            compare_field("frame_last", 32'(got.last), 32'(want.last));
            compare_field("byte_position", 32'(got.pos), 32'(want.pos));
            compare_field("frame_length", 32'(got.len), 32'(want.len));
            compare_field("profile_code", 32'(got.prof), 32'(want.prof));
            compare_field("rate_index", 32'(got.idx), 32'(want.idx));
            compare_field("sample_rate_hz", 32'(got.hz), 32'(want.hz));
            compare_field("frame_number", 32'(got.fnum), 32'(want.fnum));
         end
         checked++;
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_byte_in = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_data_byte;
   logic                 rsp_frame_start;
   logic                 rsp_frame_last;
   logic [LEN_BITS-1:0]  rsp_byte_position;
   logic [LEN_BITS-1:0]  rsp_frame_length;
   logic [1:0]           rsp_profile_code;
   logic [3:0]           rsp_rate_index;
   logic [RATE_BITS-1:0] rsp_sample_rate_hz;
   logic [FNUM_BITS-1:0] rsp_frame_number;

   frame_scoreboard sb = new();
   logic [7:0]      stream_bytes [$];
   int              frame_seq = 0;
   int unsigned     cycle_count = 0;
   int              stall_free_cycles = 0;
   logic            quiet = 1'b0;

   adts_frame_deframer_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_byte_position  (rsp_byte_position),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_profile_code   (rsp_profile_code),
      .rsp_rate_index     (rsp_rate_index),
      .rsp_sample_rate_hz (rsp_sample_rate_hz),
      .rsp_frame_number   (rsp_frame_number)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      quiet <= (cycle_count >= 120) && (cycle_count < 260);
      rsp_stall <= !quiet && ($urandom_range(99) < 27);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_data_byte, rsp_frame_start, rsp_frame_last, rsp_byte_position,
                           rsp_frame_length, rsp_profile_code, rsp_rate_index,
                           rsp_sample_rate_hz, rsp_frame_number});
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stall_free_cycles <= 0;
      else if (stall_free_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         stall_free_cycles <= stall_free_cycles + 1;
   end

   task add_header(input logic [LEN_BITS-1:0] len, input logic [7:0] second);
      logic [1:0] prof;
      logic [3:0] idx;
      prof = 2'((frame_seq / 16 + frame_seq) % 4);
      idx = 4'(frame_seq % 16);
      frame_seq++;
      stream_bytes.push_back(SYNC_BYTE);
      stream_bytes.push_back(second);
      stream_bytes.push_back({prof, idx, 2'($urandom)});
      stream_bytes.push_back({6'($urandom), len[12:11]});
      stream_bytes.push_back(len[10:3]);
      stream_bytes.push_back({len[2:0], 5'($urandom)});
      stream_bytes.push_back(8'($urandom));
   endtask

   task add_frame(input logic [LEN_BITS-1:0] len, input logic [7:0] second);
      add_header(len, second);
      for (int i = HEADER_BYTES; i < int'(len); i++)
         stream_bytes.push_back(8'($urandom));
   endtask

   task send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
   endtask

   initial begin
      int frame_items;
      int sel;
      logic [LEN_BITS-1:0] len;

      stream_bytes.push_back(8'h00);
      add_frame(HDR_LEN, SYNC_BYTE);
      stream_bytes.push_back(SYNC_BYTE);
      stream_bytes.push_back(8'h12);
      add_header(LEN_BITS'(6), {SYNC_NIBBLE, 4'h0});
      add_frame(LEN_BITS'(8), {SYNC_NIBBLE, 4'h1});

      frame_items = 0;
      while (frame_items < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 72) begin
            len = LEN_BITS'($urandom_range(7, 40));
            add_frame(len, (sel < 8) ? SYNC_BYTE : {SYNC_NIBBLE, 4'($urandom)});
            frame_items += int'(len);
         end else if (sel < 82) begin
            add_header(LEN_BITS'($urandom_range(0, 6)), {SYNC_NIBBLE, 4'($urandom)});
            frame_items += HEADER_BYTES;
         end else if (sel < 90) begin
            stream_bytes.push_back(SYNC_BYTE);
            stream_bytes.push_back(8'($urandom_range(0, 8'hEF)));
         end else begin
            repeat ($urandom_range(1, 4))
               stream_bytes.push_back(8'($urandom_range(0, 254)));
         end
      end
      add_header(LEN_BITS'(8191), {SYNC_NIBBLE, 4'h9});
      repeat (5)
         stream_bytes.push_back(8'($urandom));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (stream_bytes[i])
         send_byte(stream_bytes[i]);
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
